// File: rtl/sgli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgli_pkg
// Shared types and constants of the sub-box global/local index mapper.
// ----------------------------------------------------------------------------
package sgli_pkg;

	localparam int IDX_W     = 48;
	localparam int BEGIN_W   = 16;
	localparam int SIZE_W    = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEGIN_X  = 3'd0,
		REG_BEGIN_Y  = 3'd1,
		REG_BEGIN_Z  = 3'd2,
		REG_EXTENT_X = 3'd3,
		REG_EXTENT_Y = 3'd4,
		REG_EXTENT_Z = 3'd5,
		REG_FULL_X   = 3'd6,
		REG_FULL_Y   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		ACT_L2G = 1'b0,
		ACT_G2L = 1'b1
	} action_t;

	typedef struct packed {
		logic    vld;
		action_t act;
	} item_ctl_t;

	// box and global array geometry as held in the register file
	typedef struct packed {
		logic [2:0][BEGIN_W-1:0] bgn;
		logic [2:0][SIZE_W-1:0]  ext;
		logic [1:0][SIZE_W-1:0]  full;
	} geom_t;

endpackage
`default_nettype wire

// File: rtl/subbox_global_local_index_map_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subbox_global_local_index_map_core
// Translates indexes between a 3-D sub-box and its global array.
// ----------------------------------------------------------------------------
// The block takes one query word per clock while no result waits under
// stall, and returns one result word per query, in order. Each coordinate
// split is a restoring divider that retires one quotient bit per pipeline
// stage, followed by four stages of range check, multiply and add. While a
// result waits at the output under stall, the whole pipeline holds. Write
// the configuration registers only with the pipeline empty.
module subbox_global_local_index_map_core #(
	parameter int MAX_DIMS    = 3,
	parameter int COORD_WIDTH = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [sgli_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [sgli_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                query_valid,
	output logic                               query_stall,
	input  wire                                action,
	input  wire [sgli_pkg::IDX_W-1:0]          query_index,
	output logic                               result_valid,
	input  wire                                result_stall,
	output logic [sgli_pkg::IDX_W-1:0]         mapped_index,
	output logic                               hit
);
	import sgli_pkg::*;

	localparam int SW    = COORD_WIDTH + 1;
	localparam int NDIV  = MAX_DIMS - 1;
	localparam int NST   = NDIV * IDX_W;
	localparam int SIDEW = ((NDIV > 0) ? NDIV : 1) * SW;

	geom_t geom_q;
	logic  en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.bgn  <= '0;
			geom_q.ext  <= {3{SIZE_W'(1)}};
			geom_q.full <= {2{SIZE_W'(1)}};
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BEGIN_X:  geom_q.bgn[0]  <= cfg_data[BEGIN_W-1:0];
				REG_BEGIN_Y:  geom_q.bgn[1]  <= cfg_data[BEGIN_W-1:0];
				REG_BEGIN_Z:  geom_q.bgn[2]  <= cfg_data[BEGIN_W-1:0];
				REG_EXTENT_X: geom_q.ext[0]  <= cfg_data[SIZE_W-1:0];
				REG_EXTENT_Y: geom_q.ext[1]  <= cfg_data[SIZE_W-1:0];
				REG_EXTENT_Z: geom_q.ext[2]  <= cfg_data[SIZE_W-1:0];
				REG_FULL_X:   geom_q.full[0] <= cfg_data[SIZE_W-1:0];
				REG_FULL_Y:   geom_q.full[1] <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en          = !(result_valid && result_stall);
	assign query_stall = !en;

	item_ctl_t        ctl_p  [0:NST];
	logic [IDX_W-1:0] num_p  [0:NST];
	logic [SW-1:0]    rem_p  [0:NST];
	logic [SIDEW-1:0] side_p [0:NST];

	assign ctl_p[0]  = '{vld: query_valid, act: action_t'(action)};
	assign num_p[0]  = query_index;
	assign rem_p[0]  = '0;
	assign side_p[0] = '0;

	genvar s;
	generate
		for (s = 0; s < NST; s++) begin : g_stage
			localparam int K = s / IDX_W;
			localparam int J = s % IDX_W;
			logic [SW-1:0]    dv;
			logic [SW-1:0]    rem_in;
			logic [SIDEW-1:0] side_in;
			assign dv = (ctl_p[s].act == ACT_G2L) ? geom_q.full[K][SW-1:0]
			                                      : geom_q.ext[K][SW-1:0];
			if (J == 0 && K > 0) begin : g_first
				// park the previous remainder as a finished coordinate
				assign rem_in  = '0;
				assign side_in = side_p[s] | (SIDEW'(rem_p[s]) << ((K - 1) * SW));
			end else if (J == 0) begin : g_start
				assign rem_in  = '0;
				assign side_in = side_p[s];
			end else begin : g_mid
				assign rem_in  = rem_p[s];
				assign side_in = side_p[s];
			end
			sgli_div_step #(.SW(SW), .SIDEW(SIDEW)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctl_in  (ctl_p[s]),
				.num_in  (num_p[s]),
				.rem_in  (rem_in),
				.dv      (dv),
				.side_in (side_in),
				.ctl_s1  (ctl_p[s+1]),
				.num_s1  (num_p[s+1]),
				.rem_s1  (rem_p[s+1]),
				.side_s1 (side_p[s+1])
			);
		end
	endgenerate

	logic [SW-1:0] c0, c1;

	generate
		if (NDIV >= 2) begin : g_c2
			assign c0 = side_p[NST][SW-1:0];
			assign c1 = rem_p[NST];
		end else if (NDIV == 1) begin : g_c1
			assign c0 = rem_p[NST];
			assign c1 = '0;
		end else begin : g_c0
			assign c0 = '0;
			assign c1 = '0;
		end
	endgenerate

	sgli_combine #(.MAX_DIMS(MAX_DIMS), .COORD_WIDTH(COORD_WIDTH)) u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.geom         (geom_q),
		.ctl_in       (ctl_p[NST]),
		.c0           (c0),
		.c1           (c1),
		.rest         (num_p[NST]),
		.result_valid (result_valid),
		.mapped_index (mapped_index),
		.hit          (hit)
	);

endmodule
`default_nettype wire

// File: rtl/sgli_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgli_div_step
// One restoring division step: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module sgli_div_step #(
	parameter int SW    = 17,
	parameter int SIDEW = 34
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  sgli_pkg::item_ctl_t        ctl_in,
	input  wire [sgli_pkg::IDX_W-1:0]  num_in,
	input  wire [SW-1:0]               rem_in,
	input  wire [SW-1:0]               dv,
	input  wire [SIDEW-1:0]            side_in,
	output sgli_pkg::item_ctl_t        ctl_s1,
	output logic [sgli_pkg::IDX_W-1:0] num_s1,
	output logic [SW-1:0]              rem_s1,
	output logic [SIDEW-1:0]           side_s1
);
	import sgli_pkg::*;

	logic [SW:0] trial;
	logic [SW:0] diff;
	logic        ge;

	assign trial = {rem_in, num_in[IDX_W-1]};
	assign diff  = trial - {1'b0, dv};
	assign ge    = (trial >= {1'b0, dv});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= {num_in[IDX_W-2:0], ge};
			rem_s1  <= ge ? diff[SW-1:0] : trial[SW-1:0];
			side_s1 <= side_in;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sgli_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgli_combine
// Range checks, offset by the box origin and relinearization by the strides,
// in four register stages ending in the output register.
// ----------------------------------------------------------------------------
module sgli_combine #(
	parameter int MAX_DIMS    = 3,
	parameter int COORD_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         en,
	input  sgli_pkg::geom_t             geom,
	input  sgli_pkg::item_ctl_t         ctl_in,
	input  wire [COORD_WIDTH:0]         c0,
	input  wire [COORD_WIDTH:0]         c1,
	input  wire [sgli_pkg::IDX_W-1:0]   rest,
	output logic                        result_valid,
	output logic [sgli_pkg::IDX_W-1:0]  mapped_index,
	output logic                        hit
);
	import sgli_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int SW = CW + 1;
	localparam int PW = SW + 1;
	localparam int ND = MAX_DIMS;
	localparam int M1W = PW + SW;
	localparam int SAW = M1W + 1;
	localparam int M2W = PW + 2 * SW;
	localparam int TW  = ((SAW > M2W) ? SAW : M2W) + 1;
	localparam int XW  = (TW > IDX_W) ? TW : IDX_W;

	logic [SW-1:0] c_in [0:1];
	logic [PW-1:0] p_d  [0:2];
	logic [2:0]    miss_d;
	logic [2:0]    geo_d;
	logic [SW-1:0] s0, s1;
	logic          g2l;

	assign c_in[0] = c0;
	assign c_in[1] = c1;
	assign g2l     = (ctl_in.act == ACT_G2L);

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_dim
			logic [CW-1:0] b;
			logic [SW-1:0] e;
			assign b = geom.bgn[g][CW-1:0];
			assign e = geom.ext[g][SW-1:0];
			if (g < ND - 1) begin : g_inner
				logic [SW-1:0] cv;
				logic [SW-1:0] cd;
				assign cv = c_in[g];
				assign cd = cv - SW'(b);
				assign geo_d[g]  = (e == '0) || (geom.full[g][SW-1:0] == '0);
				assign miss_d[g] = g2l && ((cv < SW'(b)) || (cd >= e));
				assign p_d[g]    = g2l ? {1'b0, cd} : (PW'(b) + PW'(cv));
			end else if (g == ND - 1) begin : g_last
				logic [IDX_W-1:0] rd;
				assign rd        = rest - IDX_W'(b);
				assign geo_d[g]  = (e == '0);
				assign miss_d[g] = g2l ? ((rest < IDX_W'(b)) || (rd >= IDX_W'(e)))
				                       : (rest >= IDX_W'(e));
				assign p_d[g]    = g2l ? {1'b0, rd[SW-1:0]} : (PW'(b) + PW'(rest[SW-1:0]));
			end else begin : g_unused
				assign geo_d[g]  = 1'b0;
				assign miss_d[g] = 1'b0;
				assign p_d[g]    = '0;
			end
		end
		if (ND > 1) begin : g_s0
			assign s0 = g2l ? geom.ext[0][SW-1:0] : geom.full[0][SW-1:0];
		end else begin : g_s0_one
			assign s0 = SW'(1);
		end
		if (ND > 2) begin : g_s1
			assign s1 = g2l ? geom.ext[1][SW-1:0] : geom.full[1][SW-1:0];
		end else begin : g_s1_one
			assign s1 = SW'(1);
		end
	endgenerate

	item_ctl_t      ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [PW-1:0]  p0_s1, p1_s1, p2_s1;
	logic [SW-1:0]  s0_s1, s1_s1;
	logic           miss_s1, miss_s2, miss_s3;
	logic [PW-1:0]  p0_s2, p2_s2;
	logic [M1W-1:0] m1_s2;
	logic [2*SW-1:0] s01_s2;
	logic [SAW-1:0] sum_s3;
	logic [M2W-1:0] m2_s3;
	logic [IDX_W-1:0] mapped_s4;
	logic           hit_s4;
	logic [XW-1:0]  total;
	logic           ovf;

	assign total = XW'(sum_s3) + XW'(m2_s3);
	assign ovf   = (total > XW'({IDX_W{1'b1}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= p_d[0];
			p1_s1   <= p_d[1];
			p2_s1   <= p_d[2];
			s0_s1   <= s0;
			s1_s1   <= s1;
			miss_s1 <= (|miss_d) || (|geo_d);

			m1_s2   <= M1W'(p1_s1) * M1W'(s0_s1);
			s01_s2  <= (2*SW)'(s0_s1) * (2*SW)'(s1_s1);
			p0_s2   <= p0_s1;
			p2_s2   <= p2_s1;
			miss_s2 <= miss_s1;

			sum_s3  <= SAW'(p0_s2) + SAW'(m1_s2);
			m2_s3   <= M2W'(p2_s2) * M2W'(s01_s2);
			miss_s3 <= miss_s2;

			// result too wide for the index misses like any other case
			hit_s4    <= !miss_s3 && !ovf;
			mapped_s4 <= (miss_s3 || ovf) ? '0 : total[IDX_W-1:0];
		end
	end

	assign result_valid = ctl_s4.vld;
	assign mapped_index = mapped_s4;
	assign hit          = hit_s4;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit |-> mapped_index == '0)
		else $error("missed word carries a nonzero index");

	a_miss_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s3.vld && miss_s3 |=> result_valid && !hit)
		else $error("miss lost between last two stages");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_s3) && $stable(ctl_s2) && $stable(ctl_s1))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
